// ===== hdl/tkm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkm_pkg: shared types and constants of the timestamp k-way merge
// Sizes, codes, the head record, controller state and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package tkm_pkg;

	// Sources, results and field sizes
	localparam int MAX_SOURCES = 8;
	localparam int MAX_RESULTS = 8;
	localparam int SRC_W       = 3;
	localparam int CFG_W       = 4;
	localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int STAMP_W     = 32;
	localparam int KIND_W      = 8;
	localparam int COUNT_W     = 32;

	// Value of active_sources after reset
	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_SOURCES);

	// Input action codes
	localparam logic ACTION_PUSH   = 1'b0;
	localparam logic ACTION_FINISH = 1'b1;

	typedef logic [SRC_W-1:0] src_t;

	// One record as held in a head slot
	typedef struct packed {
		logic signed [STAMP_W-1:0] stamp;
		logic [KIND_W-1:0]         kind;
		logic [COUNT_W-1:0]        count_a;
		logic [COUNT_W-1:0]        count_b;
		logic [COUNT_W-1:0]        count_c;
		logic [COUNT_W-1:0]        count_d;
	} head_rec_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_EMPTY = 5'b10000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic apply;        // take the accepted input word
		logic scan_start;   // clear the minimum search
		logic scan_step;    // compare one slot
		logic emit;         // show the held record on the output
		logic emit_last;    // ... as the last one of this input
		logic load;         // move the chosen head into the output register
		logic load_empty;   // put the empty completion word out
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic blocked;   // an unfinished active source lacks a head
		logic any_head;  // some active source holds a head
		logic drained;   // every active source finished and empty
		logic scan_last; // the slot under compare is the last active one
		logic out_busy;  // output register cannot take a new word
		logic hold;      // a record waits in the output register
	} sts_t;

endpackage

// ===== hdl/tkm_ifs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkm_in_if / tkm_out_if: valid/ready channels of the merge
// Input word: push or finish for one source. Output word: one merged record
// or the empty completion word.
// ---------------------------------------------------------------------------
interface tkm_in_if;
	import tkm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      action;
	src_t                      source_id;
	logic signed [STAMP_W-1:0] stamp;
	logic [KIND_W-1:0]         kind;
	logic [COUNT_W-1:0]        count_a;
	logic [COUNT_W-1:0]        count_b;
	logic [COUNT_W-1:0]        count_c;
	logic [COUNT_W-1:0]        count_d;

	modport source (output valid, action, source_id, stamp, kind,
		count_a, count_b, count_c, count_d, input ready);
	modport sink (input valid, action, source_id, stamp, kind,
		count_a, count_b, count_c, count_d, output ready);
endinterface

interface tkm_out_if;
	import tkm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      record_valid;
	src_t                      from_source;
	logic signed [STAMP_W-1:0] out_stamp;
	logic [KIND_W-1:0]         out_kind;
	logic [COUNT_W-1:0]        out_count_a;
	logic [COUNT_W-1:0]        out_count_b;
	logic [COUNT_W-1:0]        out_count_c;
	logic [COUNT_W-1:0]        out_count_d;
	logic                      last_of_run;
	logic                      all_done;

	modport source (output valid, record_valid, from_source, out_stamp, out_kind,
		out_count_a, out_count_b, out_count_c, out_count_d, last_of_run, all_done,
		input ready);
	modport sink (input valid, record_valid, from_source, out_stamp, out_kind,
		out_count_a, out_count_b, out_count_c, out_count_d, last_of_run, all_done,
		output ready);
endinterface

// ===== hdl/tkm_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkm_ctrl: merge sequencer
// Takes one input word, then repeats minimum search and record load until
// no head may go out or the per-input limit is reached, then closes the run.
// ---------------------------------------------------------------------------
module tkm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tkm_pkg::sts_t sts,
	output tkm_pkg::cmd_t cmd
);
	import tkm_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [RES_W-1:0] count_q;
	logic             pick_ok;

	assign in_ready = (state_q == ST_IDLE);
	assign pick_ok  = (count_q < RES_W'(MAX_RESULTS)) && !sts.blocked && sts.any_head;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.apply = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (pick_ok) begin
					// a further record follows, so the held one is not last
					cmd.scan_start = 1'b1;
					cmd.emit       = sts.hold;
					state_d        = ST_SCAN;
				end else if (sts.hold) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end else if (sts.drained) begin
					state_d = ST_EMPTY;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_EMPTY: begin
				if (!sts.out_busy) begin
					cmd.load_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and records emitted for the current input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.apply) begin
				count_q <= '0;
			end else if (cmd.load) begin
				count_q <= count_q + RES_W'(1);
			end
		end
	end

endmodule

// ===== hdl/tkm_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkm_dpath: head slots, minimum search and output register
// Holds one head record per source with full and finished flags, finds the
// smallest stamp one slot per cycle and stages the result word.
// ---------------------------------------------------------------------------
module tkm_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tkm_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_action,
	input  tkm_pkg::src_t                     in_source,
	input  tkm_pkg::head_rec_t                in_rec,
	input  tkm_pkg::cmd_t                     cmd,
	output tkm_pkg::sts_t                     sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic                              out_record_valid,
	output tkm_pkg::src_t                     out_from_source,
	output tkm_pkg::head_rec_t                out_rec,
	output logic                              out_last,
	output logic                              out_done
);
	import tkm_pkg::*;

	logic [CFG_W-1:0]       active_q;
	logic [CNT_W-1:0]       n_eff;
	logic [MAX_SOURCES-1:0] act;
	logic [MAX_SOURCES-1:0] full_q;
	logic [MAX_SOURCES-1:0] fin_q;
	head_rec_t              head_q [MAX_SOURCES];
	logic                   src_ok;
	logic                   push_ok;
	src_t                   idx_q;
	src_t                   best_q;
	logic signed [STAMP_W-1:0] best_key_q;
	logic                   best_vld_q;
	logic                   take;
	logic                   out_valid_q;
	logic                   hold_q;
	logic                   rec_valid_q;
	src_t                   from_q;
	head_rec_t              out_q;
	logic                   last_q;
	logic                   done_q;

	// Effective source count and active mask
	assign n_eff = (active_q > CFG_W'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
		: CNT_W'(active_q);

	always_comb begin
		for (int i = 0; i < MAX_SOURCES; i++) begin
			act[i] = (CNT_W'(i) < n_eff);
		end
	end

	assign src_ok  = (CNT_W'(in_source) < n_eff);
	assign push_ok = cmd.apply && src_ok && (in_action == ACTION_PUSH)
		&& !fin_q[in_source] && !full_q[in_source];

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Full and finished flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			fin_q  <= '0;
		end else begin
			if (cmd.apply && src_ok && (in_action == ACTION_FINISH)) begin
				fin_q[in_source] <= 1'b1;
			end
			if (push_ok) begin
				full_q[in_source] <= 1'b1;
			end
			if (cmd.load) begin
				full_q[best_q] <= 1'b0;
			end
		end
	end

	// Head slot payload
	always_ff @(posedge clk) begin
		if (push_ok) begin
			head_q[in_source] <= in_rec;
		end
	end

	// Minimum search, one slot per cycle, lower index kept on ties
	assign take = full_q[idx_q]
		&& (!best_vld_q || ($signed(head_q[idx_q].stamp) < best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			best_vld_q <= 1'b0;
		end else if (cmd.scan_start) begin
			idx_q      <= '0;
			best_vld_q <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + SRC_W'(1);
			if (take) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && take) begin
			best_q     <= idx_q;
			best_key_q <= head_q[idx_q].stamp;
		end
	end

	// Output register control: hold_q marks a record not yet released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_q      <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b0;
			hold_q      <= 1'b1;
		end else if (cmd.load_empty || cmd.emit) begin
			out_valid_q <= 1'b1;
			hold_q      <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rec_valid_q <= 1'b1;
			from_q      <= best_q;
			out_q       <= head_q[best_q];
		end else if (cmd.load_empty) begin
			rec_valid_q <= 1'b0;
			from_q      <= '0;
			out_q       <= '0;
			last_q      <= 1'b1;
			done_q      <= 1'b1;
		end else if (cmd.emit) begin
			last_q <= cmd.emit_last;
			done_q <= cmd.emit_last && sts.drained;
		end
	end

	// Status
	assign sts.blocked   = |(act & ~full_q & ~fin_q);
	assign sts.any_head  = |(act & full_q);
	assign sts.drained   = ~|(act & (~fin_q | full_q));
	assign sts.scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == n_eff);
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign sts.hold      = hold_q;

	assign out_valid        = out_valid_q;
	assign out_record_valid = rec_valid_q;
	assign out_from_source  = from_q;
	assign out_rec          = out_q;
	assign out_last         = last_q;
	assign out_done         = done_q;

endmodule

// ===== hdl/timestamp_kway_merge_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timestamp_kway_merge_unit: merge of time-ordered record streams
// Keeps one head record per source and emits the smallest stamp whenever
// every unfinished active source holds a head.
//
//   channel   dir  handshake        word
//   rec_in    in   valid / ready    push or finish for one source
//   rec_out   out  valid / ready    merged record or completion word
//   cfg       in   cfg_we           active_sources
//
// One input word at a time; each input emits at most 8 records, and the
// minimum search for each compares one active head slot per cycle.
// A stalled output only delays the next record load or empty word; the last
// word of a run may wait while the next input is taken. arst_n clears flags,
// sets active_sources to 8 and returns the sequencer to idle.
// ---------------------------------------------------------------------------
module timestamp_kway_merge_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tkm_pkg::CFG_W-1:0] cfg_wdata,
	tkm_in_if.sink                    rec_in,
	tkm_out_if.source                 rec_out
);
	import tkm_pkg::*;

	cmd_t      cmd;
	sts_t      sts;
	head_rec_t in_rec;
	head_rec_t out_rec;

	assign in_rec.stamp   = rec_in.stamp;
	assign in_rec.kind    = rec_in.kind;
	assign in_rec.count_a = rec_in.count_a;
	assign in_rec.count_b = rec_in.count_b;
	assign in_rec.count_c = rec_in.count_c;
	assign in_rec.count_d = rec_in.count_d;

	// Sequencer
	tkm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rec_in.valid),
		.in_ready (rec_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Head slots, search and output register
	tkm_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_action        (rec_in.action),
		.in_source        (rec_in.source_id),
		.in_rec           (in_rec),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (rec_out.ready),
		.out_valid        (rec_out.valid),
		.out_record_valid (rec_out.record_valid),
		.out_from_source  (rec_out.from_source),
		.out_rec          (out_rec),
		.out_last         (rec_out.last_of_run),
		.out_done         (rec_out.all_done)
	);

	assign rec_out.out_stamp   = out_rec.stamp;
	assign rec_out.out_kind    = out_rec.kind;
	assign rec_out.out_count_a = out_rec.count_a;
	assign rec_out.out_count_b = out_rec.count_b;
	assign rec_out.out_count_c = out_rec.count_c;
	assign rec_out.out_count_d = out_rec.count_d;

endmodule

// ===== hdl/tkm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkm_checker: port-level checks of the merge unit
// Watches the top level ports only; bound to timestamp_kway_merge_unit.
// ---------------------------------------------------------------------------
module tkm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      record_valid,
	input tkm_pkg::src_t             from_source,
	input logic [tkm_pkg::STAMP_W-1:0] out_stamp,
	input logic                      last_of_run,
	input logic                      all_done
);
	import tkm_pkg::*;

	// One input word at a time: no accept in the cycle after an accept
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("tkm: input taken back to back");

	// The empty word only closes a finished merge
	a_empty_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_valid |-> last_of_run && all_done)
		else $error("tkm: empty word without completion");

	// Completion is flagged only on the last word of a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_done |-> last_of_run)
		else $error("tkm: all_done on a word that is not last");

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_stamp)
			&& $stable(from_source) && $stable(last_of_run))
		else $error("tkm: stalled output word changed");

endmodule

bind timestamp_kway_merge_unit tkm_checker u_tkm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rec_in.valid),
	.in_ready     (rec_in.ready),
	.out_valid    (rec_out.valid),
	.out_ready    (rec_out.ready),
	.record_valid (rec_out.record_valid),
	.from_source  (rec_out.from_source),
	.out_stamp    (rec_out.out_stamp),
	.last_of_run  (rec_out.last_of_run),
	.all_done     (rec_out.all_done)
);
